@@ rtl/brb_pkg.sv @@
// Shared types, codes and defaults of the byte ring buffer.
package brb_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int MAX_BURST_DEF = 8;
    localparam int CFG_W         = 9;
    localparam int CAP_LIMIT     = 256;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NO_DATA  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  count;
        logic [63:0] write_data;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_data;
        logic [7:0]  used_count;
        logic        empty_res;
        logic        full_res;
    } t_out;

    // per-burst command broadcast to every lane
    typedef struct packed {
        logic       wr;
        logic [3:0] cnt;
    } t_lane_cmd;

endpackage

@@ rtl/byte_ring_buffer_burst.sv @@
// Top level of the burst byte ring buffer with one slot kept empty.
//
//  channel  | direction | handshake                         | payload
//  ---------+-----------+-----------------------------------+-------------------
//  command  | in        | start & !busy                     | i_cmd  (t_in)
//  result   | out       | o_res_valid, one cycle, no stall  | o_res  (t_out)
//  config   | in        | i_cfg_valid & o_cfg_ready         | i_cfg_data (9 b)
//
// A command is taken every cycle; busy stays low. Its result shows up on the
// cycle after acceptance, as set by the registered read of the lane RAMs.
// Index and occupancy math (one add, one compare-subtract) finishes in the
// accept cycle, so the next command sees the updated state right away.
// Reset is synchronous, active low: indices clear, capacity returns to its top.
// The result side has no stall; each result is valid for exactly one cycle.
module byte_ring_buffer_burst #(
    parameter int DEPTH     = brb_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  brb_pkg::t_in               i_cmd,
    output logic                       o_res_valid,
    output brb_pkg::t_out              o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [brb_pkg::CFG_W-1:0]  i_cfg_data
);

    // ring capacity is bounded by both the register range and the store depth
    localparam int CAP_MAX = (DEPTH < brb_pkg::CAP_LIMIT) ? DEPTH : brb_pkg::CAP_LIMIT;
    localparam int IDX_W   = $clog2(CAP_MAX);
    localparam int CAP_W   = $clog2(CAP_MAX + 1);
    localparam int SUM_W   = ((CAP_W > 4) ? CAP_W : 4) + 1;
    // lanes: a power of two that covers the longest burst, at least two
    localparam int BANK_W  = (MAX_BURST <= 2) ? 1 : $clog2(MAX_BURST);
    localparam int NBANK   = 2**BANK_W;
    localparam int ROW_RAW = (CAP_MAX + NBANK - 1) / NBANK;
    localparam int ROW_W   = (ROW_RAW <= 2) ? 1 : $clog2(ROW_RAW);
    localparam int LIN_W   = BANK_W + ROW_W;

    // physical ring state, as seen by the user
    logic [CAP_W-1:0] r_cap;
    logic [IDX_W-1:0] r_wi, r_ri;
    logic [IDX_W-1:0] n_wi, n_ri;
    // linear storage pointers; the store is a power of two at least as big
    // as the ring, so bytes are banked by their sequence number
    logic [LIN_W-1:0] r_lwp, r_lrp;
    logic [LIN_W-1:0] n_lwp, n_lrp;

    // result stage
    logic             r_res_valid;
    logic [1:0]       r_status;
    logic [7:0]       r_used_o;
    logic             r_empty, r_full;
    logic             r_rd_ok;
    logic [BANK_W-1:0] r_rd_base;
    logic [3:0]       r_rd_cnt;

    logic             w_accept;
    logic             w_cfg_wr;
    logic [3:0]       w_cnt;
    logic [SUM_W-1:0] w_cnt_e, w_cap_e, w_used, w_room, w_used_after;
    logic [SUM_W-1:0] w_wsum, w_rsum;
    logic             w_is_wr, w_is_rd, w_wr_ok, w_rd_ok;
    logic [1:0]       w_status;
    logic [CAP_W-1:0] w_cap_clamped;
    brb_pkg::t_lane_cmd w_lane_cmd;
    logic [NBANK-1:0][7:0] w_bank_bytes;
    logic [63:0]      w_read_data;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // out-of-range capacity writes snap to the nearest legal value
    always_comb begin
        if (i_cfg_data < brb_pkg::CFG_W'(2)) begin
            w_cap_clamped = CAP_W'(2);
        end else if (i_cfg_data > brb_pkg::CFG_W'(CAP_MAX)) begin
            w_cap_clamped = CAP_W'(CAP_MAX);
        end else begin
            w_cap_clamped = CAP_W'(i_cfg_data);
        end
    end

    assign w_cnt   = (i_cmd.count > 4'(MAX_BURST)) ? 4'(MAX_BURST) : i_cmd.count;
    assign w_cnt_e = SUM_W'(w_cnt);
    assign w_cap_e = SUM_W'(r_cap);

    // occupancy from the physical indices
    assign w_used = (r_wi >= r_ri) ? (SUM_W'(r_wi) - SUM_W'(r_ri))
                                   : (w_cap_e - SUM_W'(r_ri) + SUM_W'(r_wi));
    assign w_room = w_cap_e - w_used - SUM_W'(1);

    // operation three falls through as a query
    assign w_is_wr = (i_cmd.operation == brb_pkg::OP_WRITE);
    assign w_is_rd = (i_cmd.operation == brb_pkg::OP_READ);
    assign w_wr_ok = w_is_wr && (w_cnt_e <= w_room);
    assign w_rd_ok = w_is_rd && (w_cnt_e <= w_used);

    always_comb begin
        if (w_is_wr && !w_wr_ok) begin
            w_status = brb_pkg::ST_NO_SPACE;
        end else if (w_is_rd && !w_rd_ok) begin
            w_status = brb_pkg::ST_NO_DATA;
        end else begin
            w_status = brb_pkg::ST_DONE;
        end
    end

    // index advance with wrap; burst length is below capacity, one subtract
    assign w_wsum = SUM_W'(r_wi) + w_cnt_e;
    assign w_rsum = SUM_W'(r_ri) + w_cnt_e;

    always_comb begin
        n_wi  = r_wi;
        n_ri  = r_ri;
        n_lwp = r_lwp;
        n_lrp = r_lrp;
        w_used_after = w_used;
        if (w_wr_ok) begin
            n_wi  = (w_wsum >= w_cap_e) ? IDX_W'(w_wsum - w_cap_e) : IDX_W'(w_wsum);
            n_lwp = r_lwp + LIN_W'(w_cnt);
            w_used_after = w_used + w_cnt_e;
        end else if (w_rd_ok) begin
            n_ri  = (w_rsum >= w_cap_e) ? IDX_W'(w_rsum - w_cap_e) : IDX_W'(w_rsum);
            n_lrp = r_lrp + LIN_W'(w_cnt);
            w_used_after = w_used - w_cnt_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_W'(CAP_MAX);
            r_wi        <= '0;
            r_ri        <= '0;
            r_lwp       <= '0;
            r_lrp       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= w_accept;
            if (w_cfg_wr) begin
                r_cap <= w_cap_clamped;
                r_wi  <= '0;
                r_ri  <= '0;
                r_lwp <= '0;
                r_lrp <= '0;
            end else if (w_accept) begin
                r_wi  <= n_wi;
                r_ri  <= n_ri;
                r_lwp <= n_lwp;
                r_lrp <= n_lrp;
            end
        end
    end

    // result payload; lines up with the registered bank reads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= w_status;
            r_used_o  <= 8'(w_used_after);
            r_empty   <= (w_used_after == '0);
            r_full    <= (w_used_after == w_cap_e - SUM_W'(1));
            r_rd_ok   <= w_rd_ok;
            r_rd_base <= r_lrp[BANK_W-1:0];
            r_rd_cnt  <= w_cnt;
        end
    end

    assign w_lane_cmd.wr  = w_accept && w_wr_ok;
    assign w_lane_cmd.cnt = w_cnt;

    for (genvar b = 0; b < NBANK; b++) begin : g_lane
        brb_lane #(
            .BANK_ID (b),
            .BANK_W  (BANK_W),
            .ROW_W   (ROW_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_cmd   (w_lane_cmd),
            .i_wptr  (r_lwp),
            .i_rptr  (r_lrp),
            .i_wdata (i_cmd.write_data),
            .o_rdata (w_bank_bytes[b])
        );
    end

    brb_merge #(
        .BANK_W    (BANK_W),
        .MAX_BURST (MAX_BURST)
    ) u_merge (
        .i_bytes (w_bank_bytes),
        .i_base  (r_rd_base),
        .i_cnt   (r_rd_cnt),
        .i_en    (r_rd_ok),
        .o_data  (w_read_data)
    );

    assign o_res_valid      = r_res_valid;
    assign o_res.status     = r_status;
    assign o_res.read_data  = w_read_data;
    assign o_res.used_count = r_used_o;
    assign o_res.empty_res  = r_empty;
    assign o_res.full_res   = r_full;

    // every accepted command yields its result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_res_valid)
        else $error("accepted command produced no result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(w_accept))
        else $error("result without a command");

    // banked store and physical ring must agree on occupancy
    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LIN_W'(r_lwp - r_lrp) == LIN_W'(w_used))
        else $error("linear pointers out of step with ring indices");

    // one slot always stays free
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used < w_cap_e)
        else $error("occupancy reached capacity");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != brb_pkg::ST_DONE) |-> (o_res.read_data == '0))
        else $error("refused burst returned data");

endmodule

@@ rtl/brb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/brb_lane.sv @@
// One storage lane: picks its byte of a burst and owns one RAM bank.
module brb_lane #(
    parameter int BANK_ID = 0,
    parameter int BANK_W  = 3,
    parameter int ROW_W   = 5
) (
    input  logic                      i_clk,
    input  brb_pkg::t_lane_cmd        i_cmd,
    input  logic [BANK_W+ROW_W-1:0]   i_wptr,
    input  logic [BANK_W+ROW_W-1:0]   i_rptr,
    input  logic [63:0]               i_wdata,
    output logic [7:0]                o_rdata
);

    localparam int LIN_W = BANK_W + ROW_W;

    logic [BANK_W-1:0] w_wofs;
    logic [BANK_W-1:0] w_rofs;
    logic [LIN_W-1:0]  w_wsum;
    logic [LIN_W-1:0]  w_rsum;
    logic              w_we;
    logic [7:0]        w_byte;

    // burst position that lands in this bank
    assign w_wofs = BANK_W'(BANK_ID) - i_wptr[BANK_W-1:0];
    assign w_rofs = BANK_W'(BANK_ID) - i_rptr[BANK_W-1:0];
    assign w_wsum = i_wptr + LIN_W'(w_wofs);
    assign w_rsum = i_rptr + LIN_W'(w_rofs);
    assign w_we   = i_cmd.wr && (4'(w_wofs) < i_cmd.cnt);
    assign w_byte = i_wdata[8*w_wofs +: 8];

    brb_ram #(
        .WIDTH (8),
        .DEPTH (2**ROW_W)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wsum[LIN_W-1:BANK_W]),
        .i_wdata (w_byte),
        .i_raddr (w_rsum[LIN_W-1:BANK_W]),
        .o_rdata (o_rdata)
    );

endmodule

@@ rtl/brb_merge.sv @@
// Merge stage: rotates bank outputs into burst order and masks unused lanes.
module brb_merge #(
    parameter int BANK_W    = 3,
    parameter int MAX_BURST = 8
) (
    input  logic [2**BANK_W-1:0][7:0] i_bytes,
    input  logic [BANK_W-1:0]         i_base,
    input  logic [3:0]                i_cnt,
    input  logic                      i_en,
    output logic [63:0]               o_data
);

    always_comb begin
        o_data = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < MAX_BURST && i_en && 4'(k) < i_cnt) begin
                o_data[8*k +: 8] = i_bytes[i_base + BANK_W'(k)];
            end
        end
    end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the burst byte ring buffer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation code three has no name in the package; the block treats it as a query.
    localparam logic [1:0]  OP_SPARE  = 2'd3;
    localparam logic [63:0] ALL_ONES  = '1;
    localparam int          WATCHDOG  = 1000;
    localparam int          N_PHASE   = 6;
    localparam int          MODE_LEN  = 96;   // items per fill or drain stretch
    localparam int          IDLE_PCT  = 12;

    typedef enum logic { ROW_CMD, ROW_CFG } t_row_kind;

    // One row of the directed table. For ROW_CFG only cap matters. When fixed is
    // set the result fields are typed in; otherwise the predictor decides.
    typedef struct {
        t_row_kind   kind;
        logic [8:0]  cap;
        logic [1:0]  op;
        logic [3:0]  cnt;
        logic [63:0] wdata;
        bit          fixed;
        logic [1:0]  status;
        logic [63:0] rdata;
        logic [7:0]  used;
        bit          empty;
        bit          full;
    } t_stim_row;

    localparam int N_DIR = 26;

    t_stim_row directed [N_DIR] = '{
        // fresh after reset, capacity 256
        '{ROW_CMD, 9'd0, brb_pkg::OP_QUERY, 4'd0, 64'h0,
          1'b1, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b1, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd1, 64'h0,
          1'b1, brb_pkg::ST_NO_DATA, 64'h0, 8'd0, 1'b1, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd8, ALL_ONES,
          1'b1, brb_pkg::ST_DONE, 64'h0, 8'd8, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd8, 64'h0,
          1'b1, brb_pkg::ST_DONE, ALL_ONES, 8'd0, 1'b1, 1'b0},
        // oversize counts clamp to the burst limit
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd15, 64'h0123_4567_89AB_CDEF,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd15, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, OP_SPARE, 4'd4, ALL_ONES,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        // zero-length bursts move nothing
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd0, 64'hDEAD_BEEF_CAFE_F00D,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd0, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        // lanes above count must be dropped
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd3, 64'hFFFF_FFFF_FF11_2233,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd4, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd3, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        // capacity below range acts as 2: one byte makes it full
        '{ROW_CFG, 9'd0, brb_pkg::OP_QUERY, 4'd0, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd1, 64'hA5,
          1'b1, brb_pkg::ST_DONE, 64'h0, 8'd1, 1'b0, 1'b1},
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd1, 64'h5A,
          1'b1, brb_pkg::ST_NO_SPACE, 64'h0, 8'd1, 1'b0, 1'b1},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd1, 64'h0,
          1'b1, brb_pkg::ST_DONE, 64'hA5, 8'd0, 1'b1, 1'b0},
        // capacity 9: a full burst fills it, then wrap on both indices
        '{ROW_CFG, 9'd9, brb_pkg::OP_QUERY, 4'd0, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd8, 64'h8877_6655_4433_2211,
          1'b1, brb_pkg::ST_DONE, 64'h0, 8'd8, 1'b0, 1'b1},
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd0, ALL_ONES,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd1, ALL_ONES,
          1'b1, brb_pkg::ST_NO_SPACE, 64'h0, 8'd8, 1'b0, 1'b1},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd5, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_WRITE, 4'd5, 64'h00F0_E0D0_C0B0_A090,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_READ, 4'd8, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        // out-of-range writes on both sides, last one leaves 256
        '{ROW_CFG, 9'd1, brb_pkg::OP_QUERY, 4'd0, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CFG, 9'd511, brb_pkg::OP_QUERY, 4'd0, 64'h0,
          1'b0, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b0, 1'b0},
        '{ROW_CMD, 9'd0, brb_pkg::OP_QUERY, 4'd0, 64'h0,
          1'b1, brb_pkg::ST_DONE, 64'h0, 8'd0, 1'b1, 1'b0}
    };

    int phase_len [N_PHASE] = '{320, 120, 150, 200, 100, 160};

    // DUT ports; every input has a known value from time zero
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          start       = 1'b0;
    logic          busy;
    brb_pkg::t_in  i_cmd       = '0;
    logic          o_res_valid;
    brb_pkg::t_out o_res;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [8:0]    i_cfg_data  = '0;

    // Typed-in expectation rides along with the command it belongs to.
    bit            cmd_fixed     = 1'b0;
    brb_pkg::t_out cmd_fixed_exp = '0;

    // Shadow copy of the ring, advanced at every accepted item.
    logic [7:0]  shadow_bytes [brb_pkg::DEPTH_DEF];
    int unsigned shadow_wr;
    int unsigned shadow_rd;
    int unsigned shadow_cap;

    brb_pkg::t_out pending [$];    // expected results, oldest first
    int   n_fail   = 0;
    int   quiet    = 0;
    int   idle_pct = IDLE_PCT;

    byte_ring_buffer_burst u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_cap(input logic [8:0] v);
        int unsigned top;
        top = (brb_pkg::DEPTH_DEF < brb_pkg::CAP_LIMIT) ? brb_pkg::DEPTH_DEF
                                                        : brb_pkg::CAP_LIMIT;
        if (v < 2) return 2;
        if (v > top) return top;
        return 32'(v);
    endfunction

    // index step with wrap as a conditional subtract
    function automatic int unsigned ring_next(input int unsigned i);
        int unsigned n;
        n = i + 1;
        if (n >= shadow_cap) n -= shadow_cap;
        return n;
    endfunction

    function automatic int unsigned ring_fill();
        if (shadow_wr >= shadow_rd) return shadow_wr - shadow_rd;
        return shadow_cap - shadow_rd + shadow_wr;
    endfunction

    // All-or-nothing burst against the shadow ring; returns the result it should give.
    function automatic brb_pkg::t_out predict_burst(input brb_pkg::t_in c);
        brb_pkg::t_out r;
        int unsigned   n;
        int unsigned   held;
        r    = '0;
        n    = (c.count > brb_pkg::MAX_BURST_DEF) ? brb_pkg::MAX_BURST_DEF : c.count;
        held = ring_fill();
        case (c.operation)
            brb_pkg::OP_WRITE: begin
                if (n > shadow_cap - held - 1) begin
                    r.status = brb_pkg::ST_NO_SPACE;
                end else begin
                    for (int k = 0; k < n; k++) begin
                        shadow_bytes[shadow_wr] = c.write_data[8*k +: 8];
                        shadow_wr = ring_next(shadow_wr);
                    end
                end
            end
            brb_pkg::OP_READ: begin
                if (n > held) begin
                    r.status = brb_pkg::ST_NO_DATA;
                end else begin
                    for (int k = 0; k < n; k++) begin
                        r.read_data[8*k +: 8] = shadow_bytes[shadow_rd];
                        shadow_rd = ring_next(shadow_rd);
                    end
                end
            end
            default: ;  // query, and the spare code acts the same
        endcase
        r.used_count = 8'(ring_fill());
        r.empty_res  = (shadow_rd == shadow_wr);
        r.full_res   = (ring_next(shadow_wr) == shadow_rd);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check the result of the previous item first, then record
    // any item or capacity write taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        brb_pkg::t_out want;
        brb_pkg::t_out pred;
        if (!i_rst_n) begin
            shadow_wr  = 0;
            shadow_rd  = 0;
            shadow_cap = clamp_cap(9'd256);
            pending.delete();
        end else begin
            if (o_res_valid) begin
                if (pending.size() == 0) begin
                    $error("result with no item outstanding");
                    n_fail++;
                end else begin
                    want = pending.pop_front();
                    if (o_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_res.status);
                        n_fail++;
                    end
                    if (o_res.read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h",
                               want.read_data, o_res.read_data);
                        n_fail++;
                    end
                    if (o_res.used_count !== want.used_count) begin
                        $error("used_count: expected %0d, got %0d",
                               want.used_count, o_res.used_count);
                        n_fail++;
                    end
                    if (o_res.empty_res !== want.empty_res) begin
                        $error("empty_res: expected %0d, got %0d",
                               want.empty_res, o_res.empty_res);
                        n_fail++;
                    end
                    if (o_res.full_res !== want.full_res) begin
                        $error("full_res: expected %0d, got %0d",
                               want.full_res, o_res.full_res);
                        n_fail++;
                    end
                end
            end
            if (start && !busy) begin
                // the predictor always runs so the shadow state keeps pace
                pred = predict_burst(i_cmd);
                pending.push_back(cmd_fixed ? cmd_fixed_exp : pred);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                shadow_cap = clamp_cap(i_cfg_data);
                shadow_wr  = 0;
                shadow_rd  = 0;
            end
        end
    end

    // Watchdog: any cycle without a handshake or a result counts toward the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    // Random gaps first, then hold start until the item is taken. Start is
    // left high afterwards so back-to-back items need no toggle.
    task automatic issue(input brb_pkg::t_in c, input bit fixed, input brb_pkg::t_out fx);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= c;
        cmd_fixed     <= fixed;
        cmd_fixed_exp <= fx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Stop sending and wait until every outstanding result is back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    // Capacity writes only happen with the ring idle.
    task automatic write_capacity(input logic [8:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly one direction per stretch so the ring swings between empty and full;
    // a few percent go the other way, plus queries and the spare code.
    function automatic brb_pkg::t_in random_item(input bit filling);
        brb_pkg::t_in c;
        int unsigned  roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            c.operation = ($urandom_range(3) == 0) ? OP_SPARE : brb_pkg::OP_QUERY;
        end else if (roll < 92) begin
            c.operation = filling ? brb_pkg::OP_WRITE : brb_pkg::OP_READ;
        end else begin
            c.operation = filling ? brb_pkg::OP_READ : brb_pkg::OP_WRITE;
        end
        c.count      = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                                : 4'($urandom_range(8));
        c.write_data = {$urandom, $urandom};
        return c;
    endfunction

    initial begin
        brb_pkg::t_in  c;
        brb_pkg::t_out fx;
        logic [8:0]    cap;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                write_capacity(directed[i].cap);
            end else begin
                c.operation   = directed[i].op;
                c.count       = directed[i].cnt;
                c.write_data  = directed[i].wdata;
                fx.status     = directed[i].status;
                fx.read_data  = directed[i].rdata;
                fx.used_count = directed[i].used;
                fx.empty_res  = directed[i].empty;
                fx.full_res   = directed[i].full;
                issue(c, directed[i].fixed, fx);
            end
        end

        // random phases, each under its own capacity
        for (int p = 0; p < N_PHASE; p++) begin
            case (p)
                0:       cap = 9'd256;
                1:       cap = 9'd3;
                2:       cap = 9'($urandom_range(40, 2));
                3:       cap = 9'd300;
                4:       cap = 9'd2;
                default: cap = 9'($urandom_range(511, 0));
            endcase
            write_capacity(cap);
            idle_pct = (p == 2) ? 0 : IDLE_PCT;  // one phase runs with no gaps
            for (int n = 0; n < phase_len[p]; n++) begin
                // mid-phase pause until the ring has answered everything
                if (p == 3 && n == phase_len[p] / 2) drain_results();
                issue(random_item(((n / MODE_LEN) % 2) == 0), 1'b0, '0);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (pending.size() != 0) begin
            $error("%0d results never arrived", pending.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
